@@ rtl/core/wvp_pkg.sv @@
// Shared types and constants for the wheel velocity PID block.
package wvp_pkg;

  localparam int GAIN_W     = 16;
  localparam int OUT_W      = 16;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] REG_PROP  = 2'd0;
  localparam logic [1:0] REG_INTEG = 2'd1;
  localparam logic [1:0] REG_DERIV = 2'd2;
  localparam logic [1:0] REG_STEP  = 2'd3;

  localparam logic [GAIN_W-1:0] STEP_RESET = 16'd66;

  typedef struct packed {
    logic [GAIN_W-1:0] prop;
    logic [GAIN_W-1:0] integ;
    logic [GAIN_W-1:0] deriv;
    logic [GAIN_W-1:0] step;
  } gains_t;

endpackage

@@ rtl/core/wvp_cfg.sv @@
// APB register file holding the PID gains and the integration step.
module wvp_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [wvp_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [wvp_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [wvp_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready,
  output wvp_pkg::gains_t                  gains
);

  logic                          wr_en;
  logic [wvp_pkg::GAIN_W-1:0]    rd_val;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      gains.prop  <= '0;
      gains.integ <= '0;
      gains.deriv <= '0;
      gains.step  <= wvp_pkg::STEP_RESET;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        wvp_pkg::REG_PROP:  gains.prop  <= pwdata[wvp_pkg::GAIN_W-1:0];
        wvp_pkg::REG_INTEG: gains.integ <= pwdata[wvp_pkg::GAIN_W-1:0];
        wvp_pkg::REG_DERIV: gains.deriv <= pwdata[wvp_pkg::GAIN_W-1:0];
        wvp_pkg::REG_STEP:  gains.step  <= pwdata[wvp_pkg::GAIN_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      wvp_pkg::REG_PROP:  rd_val = gains.prop;
      wvp_pkg::REG_INTEG: rd_val = gains.integ;
      wvp_pkg::REG_DERIV: rd_val = gains.deriv;
      wvp_pkg::REG_STEP:  rd_val = gains.step;
    endcase
  end

  assign prdata = {{(wvp_pkg::CFG_DATA_W - wvp_pkg::GAIN_W){1'b0}}, rd_val};

endmodule

@@ rtl/core/wvp_err.sv @@
// Error front end: velocity average, wall correction and error saturation.
module wvp_err #(
  parameter int VEL_WIDTH = 16
) (
  input  logic signed [VEL_WIDTH-1:0] tgt,
  input  logic signed [VEL_WIDTH-1:0] lv,
  input  logic signed [VEL_WIDTH-1:0] rv,
  input  logic signed [VEL_WIDTH-1:0] corr,
  input  logic                        rev,
  output logic signed [VEL_WIDTH+1:0] err
);

  localparam int ERR_W = VEL_WIDTH + 2;
  localparam int RAW_W = VEL_WIDTH + 4;

  logic signed [RAW_W-1:0] t2, c2, sum, s2, raw;
  logic                    in_range;

  always_comb begin
    t2  = RAW_W'(tgt) <<< 1;
    c2  = RAW_W'(corr) <<< 1;
    sum = RAW_W'(lv) + RAW_W'(rv);
    s2  = rev ? -sum : sum;
    raw = t2 - s2 - c2;
    // error is Q.1; clamp to ERR_W signed
    in_range = (&raw[RAW_W-1:ERR_W-1]) | ~(|raw[RAW_W-1:ERR_W-1]);
    if (in_range) begin
      err = raw[ERR_W-1:0];
    end else if (raw[RAW_W-1]) begin
      err = {1'b1, {(ERR_W-1){1'b0}}};
    end else begin
      err = {1'b0, {(ERR_W-1){1'b1}}};
    end
  end

endmodule

@@ rtl/core/wvp_mul.sv @@
// Shared signed-by-unsigned multiplier with a registered product.
module wvp_mul #(
  parameter int A_W = 32
) (
  input  logic                                 clk,
  input  logic signed [A_W-1:0]                a,
  input  logic        [wvp_pkg::GAIN_W-1:0]    b,
  output logic signed [A_W+wvp_pkg::GAIN_W:0]  p
);

  logic signed [wvp_pkg::GAIN_W:0] b_s;

  assign b_s = $signed({1'b0, b});

  always_ff @(posedge clk) begin
    p <= a * b_s;
  end

endmodule

@@ rtl/core/wheel_velocity_pid.sv @@
// Top level of the two-wheel velocity PID step with a shared multiplier.
//
// Input channel (in_valid/in_ready) takes one word per control tick: target,
// both measured wheel velocities, the turn flags and both wall corrections.
// Output channel (out_valid/out_ready) returns one word per input word: the
// saturated left and right duty increments.
//
// A result word is built step by step by the sequencer: the error, then the
// single multiplier forming e*dt, e*Kp, de*Kd and integral*Ki one after the
// other, then the rounding and output steps. A new input word is taken only
// once the last one has been loaded into the output register.
// in_ready is high only while the sequencer sits idle.
//
// If the receiver stalls, the finished word waits in the output register and
// the block can already accept and work on the next input word; it holds in
// its last step until the output register frees up.
//
// Reset (rst, synchronous) clears the integrator, previous error and output
// valid flag and restores the gains to reset values. Gains are to be written
// over the APB port while the block is idle; the block does not enforce it.
module wheel_velocity_pid #(
  parameter int VEL_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [wvp_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [wvp_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [wvp_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                pready,
  // input words
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [VEL_WIDTH-1:0]         target_velocity,
  input  logic signed [VEL_WIDTH-1:0]         left_velocity,
  input  logic signed [VEL_WIDTH-1:0]         right_velocity,
  input  logic                                reverse_turn,
  input  logic                                rotation_mode,
  input  logic signed [VEL_WIDTH-1:0]         side_correction,
  input  logic signed [VEL_WIDTH-1:0]         front_correction,
  // result words
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [wvp_pkg::OUT_W-1:0]    left_duty_step,
  output logic signed [wvp_pkg::OUT_W-1:0]    right_duty_step
);

  localparam int ERR_W = VEL_WIDTH + 2;
  localparam int DIF_W = VEL_WIDTH + 3;
  localparam int MA_W  = (DIF_W > 32) ? DIF_W : 32;   // multiplier A operand
  localparam int P_W   = MA_W + wvp_pkg::GAIN_W + 1;  // product
  localparam int SUM_W = P_W - 8;                     // integrator update
  localparam int ACC_W = MA_W + 26;                   // Q.16 accumulator
  localparam int V_W   = ACC_W - 16;
  localparam int OUT_W = wvp_pkg::OUT_W;

  // sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ERR  = 4'd1;  // error computed
  localparam logic [3:0] S_M1   = 4'd2;  // issue e*dt
  localparam logic [3:0] S_M2   = 4'd3;  // integrate, issue e*Kp
  localparam logic [3:0] S_M3   = 4'd4;  // acc = P, issue de*Kd
  localparam logic [3:0] S_M4   = 4'd5;  // acc += D, issue integral*Ki
  localparam logic [3:0] S_M5   = 4'd6;  // acc += I
  localparam logic [3:0] S_DIV  = 4'd7;  // truncate toward zero
  localparam logic [3:0] S_FIN  = 4'd8;  // negate, saturate, load output

  localparam logic signed [ACC_W-1:0] RND = ACC_W'(65535);

  wvp_pkg::gains_t gains;

  logic [3:0] state, state_next;

  // latched input word
  logic signed [VEL_WIDTH-1:0] tgt, lv, rv, corr;
  logic                        rev, rot;

  logic signed [ERR_W-1:0]  e_calc, e, last_error;
  logic signed [DIF_W-1:0]  diff;
  logic signed [31:0]       error_sum;
  logic signed [ACC_W-1:0]  acc, acc_rnd;
  logic signed [V_W-1:0]    v;

  logic signed [MA_W-1:0]           mul_a;
  logic [wvp_pkg::GAIN_W-1:0]       mul_b;
  logic signed [P_W-1:0]            prod;

  logic signed [SUM_W-1:0] es_sum;
  logic                    es_ok;
  logic signed [V_W:0]     vx, l_raw, r_raw;
  logic                    l_ok, r_ok;
  logic signed [OUT_W-1:0] l_sat, r_sat;
  logic                    out_load;

  wvp_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .gains   (gains)
  );

  wvp_err #(.VEL_WIDTH(VEL_WIDTH)) u_err (
    .tgt  (tgt),
    .lv   (lv),
    .rv   (rv),
    .corr (corr),
    .rev  (rev),
    .err  (e_calc)
  );

  wvp_mul #(.A_W(MA_W)) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  assign in_ready = (state == S_IDLE);
  assign out_load = (state == S_FIN) && (!out_valid || out_ready);
  assign diff     = DIF_W'(e) - DIF_W'(last_error);

  // multiplier operand select
  always_comb begin
    unique case (state)
      S_M1: begin
        mul_a = MA_W'(e);
        mul_b = gains.step;
      end
      S_M2: begin
        mul_a = MA_W'(e);
        mul_b = gains.prop;
      end
      S_M3: begin
        mul_a = MA_W'(diff);
        mul_b = gains.deriv;
      end
      S_M4: begin
        mul_a = MA_W'(error_sum);
        mul_b = gains.integ;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // integrator update: floor(e*dt / 2^9), clamped to 32 bits
  always_comb begin
    es_sum = SUM_W'(error_sum) + SUM_W'(prod >>> 9);
    es_ok  = (&es_sum[SUM_W-1:31]) | ~(|es_sum[SUM_W-1:31]);
  end

  // rounding toward zero before the /2^16
  assign acc_rnd = acc + (acc[ACC_W-1] ? RND : '0);

  // output negation and saturation
  always_comb begin
    vx    = (V_W+1)'(v);
    l_raw = (rot ^ rev) ? -vx : vx;
    r_raw = rev ? -vx : vx;
    l_ok  = (&l_raw[V_W:OUT_W-1]) | ~(|l_raw[V_W:OUT_W-1]);
    r_ok  = (&r_raw[V_W:OUT_W-1]) | ~(|r_raw[V_W:OUT_W-1]);
    if (l_ok) begin
      l_sat = l_raw[OUT_W-1:0];
    end else begin
      l_sat = l_raw[V_W] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
    end
    if (r_ok) begin
      r_sat = r_raw[OUT_W-1:0];
    end else begin
      r_sat = r_raw[V_W] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
    end
  end

  always_comb begin
    unique case (state)
      S_IDLE:  state_next = in_valid ? S_ERR : S_IDLE;
      S_ERR:   state_next = S_M1;
      S_M1:    state_next = S_M2;
      S_M2:    state_next = S_M3;
      S_M3:    state_next = S_M4;
      S_M4:    state_next = S_M5;
      S_M5:    state_next = S_DIV;
      S_DIV:   state_next = S_FIN;
      S_FIN:   state_next = out_load ? S_IDLE : S_FIN;
      default: state_next = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      error_sum  <= '0;
      last_error <= '0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (state == S_M2) begin
        if (es_ok) begin
          error_sum <= es_sum[31:0];
        end else begin
          error_sum <= es_sum[SUM_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
      end
      // diff was consumed when de*Kd was issued
      if (state == S_M4) begin
        last_error <= e;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      tgt  <= target_velocity;
      lv   <= left_velocity;
      rv   <= right_velocity;
      corr <= rotation_mode ? side_correction : front_correction;
      rev  <= reverse_turn;
      rot  <= rotation_mode;
    end
    if (state == S_ERR) begin
      e <= e_calc;
    end
    unique case (state)
      S_M3:    acc <= ACC_W'(prod) <<< 7;
      S_M4:    acc <= acc + (ACC_W'(prod) <<< 7);
      S_M5:    acc <= acc + ACC_W'(prod);
      default: acc <= acc;
    endcase
    if (state == S_DIV) begin
      v <= acc_rnd[ACC_W-1:16];
    end
    if (out_load) begin
      left_duty_step  <= l_sat;
      right_duty_step <= r_sat;
    end
  end

endmodule

@@ rtl/core/wvp_check.sv @@
// Port-level checker for the wheel velocity PID block, bound to the top level.
module wvp_check #(
  parameter int VEL_WIDTH = 16
) (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic signed [wvp_pkg::OUT_W-1:0] left_duty_step,
  input logic signed [wvp_pkg::OUT_W-1:0] right_duty_step
);

  // an offered input word is held until taken
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid)
    else $error("input word dropped before acceptance");

  // one word at a time: ready drops right after an accept
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("block ready again right after accepting a word");

  // a stalled result word holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(left_duty_step)
      && $stable(right_duty_step))
    else $error("result word changed or dropped while stalled");

  // reset leaves the block idle with no result pending
  a_reset: assert property (@(posedge clk)
    rst |=> in_ready && !out_valid)
    else $error("block not idle after reset");

endmodule

bind wheel_velocity_pid wvp_check #(.VEL_WIDTH(VEL_WIDTH)) u_check (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .left_duty_step  (left_duty_step),
  .right_duty_step (right_duty_step)
);
